[hw/rtl/evtt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtt_pkg
// Shared types and constants of the encoder vote and turn tracker.
// ----------------------------------------------------------------------------
package evtt_pkg;

  localparam int COUNT_BITS  = 12;
  localparam int HALF_COUNTS = 1 << (COUNT_BITS - 1);
  localparam int WIN_W       = 12;
  localparam int TURN_W      = 16;
  localparam int POS_W       = TURN_W + COUNT_BITS;
  localparam int AXIS_W      = 2;

  localparam logic [WIN_W-1:0]         WINDOW_RESET = WIN_W'(8);
  localparam logic signed [TURN_W-1:0] TURN_MAX     = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN     = 16'sh8000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_READ_FAIL = 2'd1,
    ST_NO_AGREE  = 2'd2,
    ST_CLEARED   = 2'd3
  } status_e;

  typedef struct packed {
    logic                  read_ok;
    logic                  agree;
    logic [COUNT_BITS-1:0] mean;
  } vote_t;

  typedef struct packed {
    logic clear;
    logic commit;
  } trk_cmd_t;

endpackage

[hw/rtl/evtt_vote.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtt_vote
// Pairwise agreement check and circular mean of the first agreeing pair of three position readings.
// ----------------------------------------------------------------------------
module evtt_vote (
  input  logic [evtt_pkg::COUNT_BITS-1:0] sample_a_i,
  input  logic [evtt_pkg::COUNT_BITS-1:0] sample_b_i,
  input  logic [evtt_pkg::COUNT_BITS-1:0] sample_c_i,
  input  logic                            a_ok_i,
  input  logic                            b_ok_i,
  input  logic                            c_ok_i,
  input  logic [evtt_pkg::WIN_W-1:0]      window_i,
  output evtt_pkg::vote_t                 vote_o
);

  localparam int CB = evtt_pkg::COUNT_BITS;
  localparam logic [CB:0] FULL_C = (CB+1)'(1 << CB);

  function automatic logic signed [CB:0] wrap_delta(input logic [CB-1:0] x,
                                                    input logic [CB-1:0] y);
    logic signed [CB:0] d;
    d = $signed({1'b0, x}) - $signed({1'b0, y});
    if (d > evtt_pkg::HALF_COUNTS) begin
      d = d - FULL_C;
    end else if (d < -evtt_pkg::HALF_COUNTS) begin
      d = d + FULL_C;
    end
    return d;
  endfunction

  function automatic logic agrees(input logic signed [CB:0] d,
                                  input logic [evtt_pkg::WIN_W-1:0] win);
    logic [CB:0] mag;
    mag = (d < 0) ? (CB+1)'(-d) : d;
    return mag <= (CB+1)'(win);
  endfunction

  // x plus half the delta, truncated toward zero, modulo full scale
  function automatic logic [CB-1:0] wrap_mean(input logic [CB-1:0] x,
                                              input logic signed [CB:0] d);
    logic signed [CB:0] half;
    half = (d + $signed({{CB{1'b0}}, d[CB]})) >>> 1;
    return x + half[CB-1:0];
  endfunction

  logic signed [CB:0] d_ba, d_ca, d_cb;

  assign d_ba = wrap_delta(sample_b_i, sample_a_i);
  assign d_ca = wrap_delta(sample_c_i, sample_a_i);
  assign d_cb = wrap_delta(sample_c_i, sample_b_i);

  always_comb begin
    vote_o.read_ok = a_ok_i & b_ok_i & c_ok_i;
    vote_o.agree   = 1'b1;
    if (agrees(d_ba, window_i)) begin
      vote_o.mean = wrap_mean(sample_a_i, d_ba);
    end else if (agrees(d_ca, window_i)) begin
      vote_o.mean = wrap_mean(sample_a_i, d_ca);
    end else if (agrees(d_cb, window_i)) begin
      vote_o.mean = wrap_mean(sample_b_i, d_cb);
    end else begin
      vote_o.agree = 1'b0;
      vote_o.mean  = '0;
    end
  end

endmodule

[hw/rtl/evtt_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtt_track
// Per-axis last count and saturating turn counter.
// ----------------------------------------------------------------------------
module evtt_track #(
  parameter int AXES = 3
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [((AXES > 1) ? $clog2(AXES) : 1)-1:0] idx_i,
  input  evtt_pkg::trk_cmd_t                     cmd_i,
  input  logic [evtt_pkg::COUNT_BITS-1:0]        mean_i,
  output logic [evtt_pkg::COUNT_BITS-1:0]        cur_count_o,
  output logic signed [evtt_pkg::TURN_W-1:0]     cur_turns_o,
  output logic signed [evtt_pkg::TURN_W-1:0]     next_turns_o
);

  localparam int CB = evtt_pkg::COUNT_BITS;

  logic [CB-1:0]                     last_count_q [AXES];
  logic signed [evtt_pkg::TURN_W-1:0] turns_q     [AXES];
  logic signed [CB:0]                change;

  assign cur_count_o = last_count_q[idx_i];
  assign cur_turns_o = turns_q[idx_i];
  assign change      = $signed({1'b0, mean_i}) - $signed({1'b0, cur_count_o});

  always_comb begin
    next_turns_o = cur_turns_o;
    if ((change > evtt_pkg::HALF_COUNTS) && (cur_turns_o != evtt_pkg::TURN_MIN)) begin
      next_turns_o = cur_turns_o - 16'sd1;
    end else if ((change < -evtt_pkg::HALF_COUNTS) &&
                 (cur_turns_o != evtt_pkg::TURN_MAX)) begin
      next_turns_o = cur_turns_o + 16'sd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        last_count_q[i] <= '0;
        turns_q[i]      <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < AXES; i++) begin
        last_count_q[i] <= '0;
        turns_q[i]      <= '0;
      end
    end else if (cmd_i.commit) begin
      last_count_q[idx_i] <= mean_i;
      turns_q[idx_i]      <= next_turns_o;
    end
  end

endmodule

[hw/rtl/encoder_vote_and_turn_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_vote_and_turn_tracker
// Votes three absolute encoder readings and tracks multiturn position.
// ----------------------------------------------------------------------------
// One item is taken per clock while the input is not stalled, and every item
// gives exactly one result. An item passes an input register and then the
// result register, which shows its result once it is loaded.
// The vote and the per-axis turn update sit combinationally between those
// registers; the axis state is written as the result register loads, so the
// next item sees it at once and back-to-back items on the same axis are
// handled at full rate. The input side stalls only while a result is held by
// a stalled output and the input register is full.
module encoder_vote_and_turn_tracker #(
  parameter int AXES = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [evtt_pkg::WIN_W-1:0]            cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  opcode_i,
  input  logic [evtt_pkg::AXIS_W-1:0]           axis_i,
  input  logic [evtt_pkg::COUNT_BITS-1:0]       sample_a_i,
  input  logic [evtt_pkg::COUNT_BITS-1:0]       sample_b_i,
  input  logic [evtt_pkg::COUNT_BITS-1:0]       sample_c_i,
  input  logic                                  a_ok_i,
  input  logic                                  b_ok_i,
  input  logic                                  c_ok_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [evtt_pkg::AXIS_W-1:0]           out_axis_o,
  output logic [1:0]                            status_o,
  output logic [evtt_pkg::COUNT_BITS-1:0]       agreed_count_o,
  output logic signed [evtt_pkg::TURN_W-1:0]    turns_o,
  output logic signed [evtt_pkg::POS_W-1:0]     multiturn_position_o
);

  localparam int CB  = evtt_pkg::COUNT_BITS;
  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

  logic [evtt_pkg::WIN_W-1:0] window_q;

  logic                          s1_valid_q;
  logic                          opcode_q;
  logic [evtt_pkg::AXIS_W-1:0]   axis_q;
  logic [CB-1:0]                 sample_a_q, sample_b_q, sample_c_q;
  logic                          a_ok_q, b_ok_q, c_ok_q;

  logic                          s2_free, s1_adv;
  logic                          in_range, is_clear;
  logic [AXW-1:0]                idx;
  evtt_pkg::vote_t               vote;
  evtt_pkg::trk_cmd_t            trk_cmd;
  logic [CB-1:0]                 cur_count;
  logic signed [evtt_pkg::TURN_W-1:0] cur_turns, next_turns;

  logic                          out_valid_q;
  logic [evtt_pkg::AXIS_W-1:0]   out_axis_d, out_axis_q;
  evtt_pkg::status_e             status_d, status_q;
  logic [CB-1:0]                 count_d, count_q;
  logic signed [evtt_pkg::TURN_W-1:0] turns_d, turns_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= evtt_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // handshake
  assign s2_free    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      opcode_q   <= opcode_i;
      axis_q     <= axis_i;
      sample_a_q <= sample_a_i;
      sample_b_q <= sample_b_i;
      sample_c_q <= sample_c_i;
      a_ok_q     <= a_ok_i;
      b_ok_q     <= b_ok_i;
      c_ok_q     <= c_ok_i;
    end
  end

  assign is_clear = (opcode_q == evtt_pkg::OP_CLEAR);
  assign in_range = (int'(axis_q) < AXES);
  assign idx      = in_range ? AXW'(axis_q) : '0;

  evtt_vote u_vote (
    .sample_a_i (sample_a_q),
    .sample_b_i (sample_b_q),
    .sample_c_i (sample_c_q),
    .a_ok_i     (a_ok_q),
    .b_ok_i     (b_ok_q),
    .c_ok_i     (c_ok_q),
    .window_i   (window_q),
    .vote_o     (vote)
  );

  assign trk_cmd.clear  = s1_adv && is_clear;
  assign trk_cmd.commit = s1_adv && !is_clear && in_range && vote.read_ok && vote.agree;

  evtt_track #(
    .AXES (AXES)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .idx_i        (idx),
    .cmd_i        (trk_cmd),
    .mean_i       (vote.mean),
    .cur_count_o  (cur_count),
    .cur_turns_o  (cur_turns),
    .next_turns_o (next_turns)
  );

  // result selection
  always_comb begin
    out_axis_d = axis_q;
    status_d   = evtt_pkg::ST_ACCEPTED;
    count_d    = vote.mean;
    turns_d    = next_turns;
    if (is_clear) begin
      out_axis_d = '0;
      status_d   = evtt_pkg::ST_CLEARED;
      count_d    = '0;
      turns_d    = '0;
    end else if (!in_range) begin
      status_d = evtt_pkg::ST_READ_FAIL;
      count_d  = '0;
      turns_d  = '0;
    end else if (!vote.read_ok) begin
      status_d = evtt_pkg::ST_READ_FAIL;
      count_d  = cur_count;
      turns_d  = cur_turns;
    end else if (!vote.agree) begin
      status_d = evtt_pkg::ST_NO_AGREE;
      count_d  = cur_count;
      turns_d  = cur_turns;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_axis_q <= out_axis_d;
      status_q   <= status_d;
      count_q    <= count_d;
      turns_q    <= turns_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_axis_o           = out_axis_q;
  assign status_o             = status_q;
  assign agreed_count_o       = count_q;
  assign turns_o              = turns_q;
  assign multiturn_position_o = {turns_q, count_q};

`ifndef SYNTH
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && is_clear) |=> (out_valid_o && (status_o == evtt_pkg::ST_CLEARED) &&
                              (agreed_count_o == '0) && (multiturn_position_o == '0)))
    else $error("clear transfer did not give a zeroed cleared result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a held result and a full input register");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !is_clear && in_range && !(vote.read_ok && vote.agree)) |=>
      ((agreed_count_o == $past(cur_count)) && (turns_o == $past(cur_turns))))
    else $error("rejected item did not report the stored axis state");
`endif

endmodule
